### design/rtslot_pkg.sv
// Shared types, codes and constants for the retransmission slot table.
package rtslot_pkg;

    localparam int SLOTS_DEFAULT = 32;

    localparam int OPCODE_W = 3;
    localparam int CONN_W   = 8;
    localparam int SEQ_W    = 16;
    localparam int SLOT_W   = 5;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int ATT_W    = 8;
    localparam int TMO_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_ENQUEUE     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_CONN = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_SLOT = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RESEND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLOSE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DISCONNECT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_MODE    = 2'd2;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET  = 16'd500;
    localparam logic [ATT_W-1:0] MAX_ATT_RESET  = 8'd10;
    localparam logic [ATT_W-1:0] ATT_MAX        = 8'hFF;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              is_enqueue;  // walk kind: 1 enqueue, 0 tick scan
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
        logic [TMO_W-1:0]  timeout;
        logic [ATT_W-1:0]  max_att;
        logic              server;
        logic              step;        // token holder acts, token moves on
        logic              shift;       // token chain loads from neighbor
        logic              kill;        // walk ends, token dropped
        logic              clr_all;
        logic              rm_conn;
        logic [CONN_W-1:0] rm_id;
        logic              rm_slot;
        logic [SLOT_W-1:0] sel;
    } cell_cmd_t;

    // Result offered by the token holder; all zero from other cells.
    typedef struct packed {
        logic                emit;
        logic                term;
        logic [STATUS_W-1:0] status;
        logic [CONN_W-1:0]   conn;
        logic [SEQ_W-1:0]    seq;
        logic [ATT_W-1:0]    att;
    } cell_res_t;

endpackage

### design/rtslot_cell.sv
// One slot of the table: entry registers, token stage and slot decision.
module rtslot_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtslot_pkg::cell_cmd_t cmd,
    input  logic                  tok_in,
    output logic                  tok_out,
    output rtslot_pkg::cell_res_t res
);
    import rtslot_pkg::*;

    logic              valid_reg, valid_next;
    logic              tok_reg, tok_next;
    logic [CONN_W-1:0] conn_reg, conn_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [TIME_W-1:0] sent_reg, sent_next;
    logic [ATT_W-1:0]  att_reg, att_next;

    logic [TIME_W-1:0] age;
    logic              due;
    logic              give_up;
    logic [ATT_W-1:0]  att_inc;
    logic              act;

    assign age     = cmd.now - sent_reg;
    assign due     = valid_reg && (age >= {{(TIME_W-TMO_W){1'b0}}, cmd.timeout});
    assign give_up = att_reg >= cmd.max_att;
    assign att_inc = (att_reg == ATT_MAX) ? ATT_MAX : att_reg + 1'b1;
    assign act     = tok_reg && cmd.step;
    assign tok_out = tok_reg;

    always_comb
    begin
        res = '0;
        if (tok_reg)
        begin
            if (cmd.is_enqueue)
            begin
                if (!valid_reg)
                begin
                    res.emit   = 1'b1;
                    res.term   = 1'b1;
                    res.status = ST_ENQUEUED;
                    res.conn   = cmd.conn;
                    res.seq    = cmd.seq;
                end
            end
            else if (due)
            begin
                res.emit = 1'b1;
                res.conn = conn_reg;
                res.seq  = seq_reg;
                if (give_up)
                begin
                    res.att    = att_reg;
                    res.status = cmd.server ? ST_CLOSE : ST_DISCONNECT;
                    res.term   = !cmd.server;
                end
                else
                begin
                    res.att    = att_inc;
                    res.status = ST_RESEND;
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        conn_next  = conn_reg;
        seq_next   = seq_reg;
        sent_next  = sent_reg;
        att_next   = att_reg;
        if (cmd.clr_all
            || (cmd.rm_conn && conn_reg == cmd.rm_id)
            || (cmd.rm_slot && cmd.sel == SLOT_W'(IDX)))
        begin
            valid_next = 1'b0;
        end
        else if (act)
        begin
            if (cmd.is_enqueue)
            begin
                if (!valid_reg)
                begin
                    valid_next = 1'b1;
                    conn_next  = cmd.conn;
                    seq_next   = cmd.seq;
                    sent_next  = cmd.now;
                    att_next   = '0;
                end
            end
            else if (due)
            begin
                if (give_up)
                begin
                    if (cmd.server)
                    begin
                        valid_next = 1'b0;
                    end
                end
                else
                begin
                    sent_next = cmd.now;
                    att_next  = att_inc;
                end
            end
        end
    end

    always_comb
    begin
        if (cmd.kill)
        begin
            tok_next = 1'b0;
        end
        else if (cmd.shift)
        begin
            tok_next = tok_in;
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conn_reg <= conn_next;
        seq_reg  <= seq_next;
        sent_reg <= sent_next;
        att_reg  <= att_next;
    end

endmodule

### design/retransmit_slot_table.sv
// Retransmission slot table: command sequencer, token-passing cell chain, result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | in_valid/in_ready  | opcode connection_id sequence_number slot_select
//           |                    | now_ticks
//  result   | out_valid/out_ready| status slot_out connection_out sequence_out
//           |                    | attempts_out last_flag
//  config   | cfg_we (no wait)   | cfg_index cfg_data
//
// Enqueue and tick scan pass a token down the row of SLOTS cells, one cell per
// cycle while the result register is free. Enqueue stops at the first free cell.
// A tick scan visits every cell and then emits done, unless a client give-up ends
// it first. Remove connection, remove slot and clear act on all cells at once and
// then report done. in_ready is high only while idle.
// Reset empties every slot at once; slot contents are not cleared.
// A stalled result register holds the token in place until the transfer.
module retransmit_slot_table #(
    parameter int SLOTS = rtslot_pkg::SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rtslot_pkg::OPCODE_W-1:0]     opcode,
    input  logic [rtslot_pkg::CONN_W-1:0]       connection_id,
    input  logic [rtslot_pkg::SEQ_W-1:0]        sequence_number,
    input  logic [rtslot_pkg::SLOT_W-1:0]       slot_select,
    input  logic [rtslot_pkg::TIME_W-1:0]       now_ticks,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rtslot_pkg::STATUS_W-1:0]     status,
    output logic [rtslot_pkg::SLOT_W-1:0]       slot_out,
    output logic [rtslot_pkg::CONN_W-1:0]       connection_out,
    output logic [rtslot_pkg::SEQ_W-1:0]        sequence_out,
    output logic [rtslot_pkg::ATT_W-1:0]        attempts_out,
    output logic                                last_flag,

    input  logic                                cfg_we,
    input  logic [rtslot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtslot_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rtslot_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [CONN_W-1:0]   conn_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [SLOT_W-1:0]   sel_reg;
    logic [TIME_W-1:0]   now_reg;

    // Configuration registers
    logic [TMO_W-1:0]    timeout_reg;
    logic [ATT_W-1:0]    max_att_reg;
    logic                server_reg;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CONN_W-1:0]   oconn_reg, oconn_next;
    logic [SEQ_W-1:0]    oseq_reg, oseq_next;
    logic [ATT_W-1:0]    oatt_reg, oatt_next;
    logic                last_reg, last_next;
    logic                out_load;

    logic                accept;
    logic                start;
    logic                out_free;
    logic                step;
    logic                walk_end;
    logic                is_enq;

    cell_cmd_t           cmd;
    cell_res_t           cell_res [SLOTS];
    cell_res_t           sel_res;
    logic [SLOTS-1:0]    tok;
    logic [SLOTS-1:0]    tok_feed;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign start    = accept && (opcode == OP_ENQUEUE || opcode == OP_TICK);
    assign out_free = !out_valid_reg || out_ready;
    assign step     = (state_reg == S_WALK) && out_free;
    assign walk_end = step && (sel_res.term || idx_reg == IDX_W'(SLOTS - 1));
    assign is_enq   = (op_reg == OP_ENQUEUE);

    // Token holder's offer; at most one cell drives nonzero.
    always_comb
    begin
        sel_res = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sel_res = sel_res | cell_res[i];
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.is_enqueue = is_enq;
        cmd.conn       = conn_reg;
        cmd.seq        = seq_reg;
        cmd.now        = now_reg;
        cmd.timeout    = timeout_reg;
        cmd.max_att    = max_att_reg;
        cmd.server     = server_reg;
        cmd.step       = step;
        cmd.shift      = step || start;
        cmd.kill       = step && sel_res.term;
        // Client give-up empties the table; clear does the same from idle.
        cmd.clr_all    = (step && sel_res.term && !is_enq)
                         || (accept && opcode == OP_CLEAR);
        cmd.rm_conn    = accept && opcode == OP_REMOVE_CONN;
        cmd.rm_id      = connection_id;
        cmd.rm_slot    = accept && opcode == OP_REMOVE_SLOT;
        cmd.sel        = slot_select;
    end

    // Token enters the first cell at start and moves one cell per step.
    assign tok_feed = {tok[SLOTS-2:0], start};

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rtslot_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .tok_in  (tok_feed[g]),
            .tok_out (tok[g]),
            .res     (cell_res[g])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    state_next = start ? S_WALK : S_FIN;
                end
            end
            S_WALK:
            begin
                if (step)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (sel_res.term)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (walk_end)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register load
    always_comb
    begin
        out_load    = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        oconn_next  = oconn_reg;
        oseq_next   = oseq_reg;
        oatt_next   = oatt_reg;
        last_next   = last_reg;
        if (step && sel_res.emit)
        begin
            out_load    = 1'b1;
            status_next = sel_res.status;
            slot_next   = SLOT_W'(idx_reg);
            oconn_next  = sel_res.conn;
            oseq_next   = sel_res.seq;
            oatt_next   = sel_res.att;
            last_next   = sel_res.term;
        end
        else if (state_reg == S_FIN && out_free)
        begin
            // Table full echoes the request; everything else reports done.
            out_load    = 1'b1;
            status_next = is_enq ? ST_FULL : ST_DONE;
            slot_next   = (op_reg == OP_REMOVE_SLOT) ? sel_reg : '0;
            oconn_next  = is_enq ? conn_reg : '0;
            oseq_next   = is_enq ? seq_reg : '0;
            oatt_next   = '0;
            last_next   = 1'b1;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            max_att_reg   <= MAX_ATT_RESET;
            server_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RESEND_TIMEOUT: timeout_reg <= cfg_data;
                    CFG_MAX_ATTEMPTS:   max_att_reg <= cfg_data[ATT_W-1:0];
                    CFG_SERVER_MODE:    server_reg  <= cfg_data[0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            conn_reg <= connection_id;
            seq_reg  <= sequence_number;
            sel_reg  <= slot_select;
            now_reg  <= now_ticks;
        end
        status_reg <= status_next;
        slot_reg   <= slot_next;
        oconn_reg  <= oconn_next;
        oseq_reg   <= oseq_next;
        oatt_reg   <= oatt_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign slot_out       = slot_reg;
    assign connection_out = oconn_reg;
    assign sequence_out   = oseq_reg;
    assign attempts_out   = oatt_reg;
    assign last_flag      = last_reg;

endmodule
